@@ hdl/swa_pkg.sv @@
// Shared types and constants for the sliding window average block.
package swa_pkg;

  localparam int WINDOW_MAX_DEF    = 64;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int LEN_REG_BITS = 7;
  localparam int SUM_OUT_BITS = 22;
  localparam int AVG_OUT_BITS = 24;

  localparam logic [LEN_REG_BITS-1:0] LEN_RESET = LEN_REG_BITS'(5);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT
  } swa_state_t;

  typedef struct packed {
    logic signed [SUM_OUT_BITS-1:0] window_sum;
    logic signed [AVG_OUT_BITS-1:0] average_q8;
  } swa_result_t;

endpackage

@@ hdl/swa_stream_if.sv @@
// Valid/ready channel carrying one payload word.
interface swa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sliding_window_average.sv @@
// Sliding window average top level: ring memory, running sum and result register.
//
// Channels: window_cfg takes a 7-bit window length (0 acts as 1, lengths above
// WINDOW_MAX act as WINDOW_MAX); each write restarts window filling. samples
// takes one signed sample word per handshake. results gives one word per
// sample once the window is full: the window sum and sum*2^FRACTION_BITS
// divided by the length, truncated toward zero.
// Each sample passes through the ring read at acceptance, the sum update and
// ring write, the bit-serial divider over DIV_BITS = SAMPLE_BITS +
// clog2(WINDOW_MAX) + FRACTION_BITS bits, the hand-over of the quotient and
// the load of the result register; the next sample is accepted only once the
// block is back in idle. Samples that only fill the window skip the divider
// and return to idle after the sum update and ring write.
// Reset clears the pointer, fill count and sum and sets the length to 5; ring
// contents stay undefined and are never used before being written.
// A stalled receiver holds the result register; the next sample is still
// accepted and processed, and the block waits to load its result until the
// previous one is taken.
module sliding_window_average
  import swa_pkg::*;
#(
  parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  swa_stream_if.sink   window_cfg,
  swa_stream_if.sink   samples,
  swa_stream_if.source results
);

  localparam int PTR_BITS = $clog2(WINDOW_MAX);
  localparam int LEN_BITS = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;
  localparam int DIV_BITS = SUM_BITS + FRACTION_BITS;

  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] ring_rdata;
  logic signed [SAMPLE_BITS-1:0] sample_reg;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  logic [LEN_REG_BITS-1:0] window_len;
  logic [LEN_BITS-1:0]     eff_len;
  logic [PTR_BITS-1:0]     write_pointer;
  logic [PTR_BITS-1:0]     old_addr;
  logic [PTR_BITS-1:0]     write_pointer_next;
  logic [LEN_BITS-1:0]     fill_count;
  logic [LEN_BITS-1:0]     fill_count_next;
  logic signed [SUM_BITS-1:0] running_sum;
  logic signed [SUM_BITS-1:0] running_sum_next;
  logic [SUM_BITS-1:0]     sum_mag;
  logic                    full;
  logic                    has_result;

  swa_state_t state, state_next;
  logic       div_start;
  logic       div_done;
  logic signed [DIV_BITS:0] div_quotient;
  logic       out_load;
  logic       out_valid;
  swa_result_t out_data;
  logic       in_accept;

  assign sample_in = SAMPLE_BITS'(samples.data);
  assign in_accept = samples.valid && samples.ready;
  assign window_cfg.ready = 1'b1;

  always_comb begin
    if (window_len == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (int'(window_len) > WINDOW_MAX) begin
      eff_len = LEN_BITS'(WINDOW_MAX);
    end else begin
      eff_len = LEN_BITS'(window_len);
    end
  end

  always_comb begin
    if (int'(write_pointer) >= int'(eff_len)) begin
      old_addr = PTR_BITS'(int'(write_pointer) - int'(eff_len));
    end else begin
      old_addr = PTR_BITS'(int'(write_pointer) + WINDOW_MAX - int'(eff_len));
    end
    if (int'(write_pointer) == WINDOW_MAX - 1) begin
      write_pointer_next = '0;
    end else begin
      write_pointer_next = write_pointer + 1'b1;
    end
    full             = fill_count >= eff_len;
    fill_count_next  = full ? fill_count : fill_count + 1'b1;
    has_result       = full || (fill_count_next == eff_len);
    running_sum_next = running_sum - (full ? SUM_BITS'(ring_rdata) : SUM_BITS'(0))
                       + SUM_BITS'(sample_reg);
    sum_mag          = running_sum_next[SUM_BITS-1] ? SUM_BITS'(-running_sum_next)
                                                    : SUM_BITS'(running_sum_next);
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ring_rdata <= ring[old_addr];
      sample_reg <= sample_in;
    end
    if (state == ST_UPDATE) begin
      ring[write_pointer] <= sample_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len    <= LEN_RESET;
      write_pointer <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (window_cfg.valid) begin
      window_len    <= LEN_REG_BITS'(window_cfg.data);
      write_pointer <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (state == ST_UPDATE) begin
      write_pointer <= write_pointer_next;
      fill_count    <= fill_count_next;
      running_sum   <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (has_result) begin
          div_start  = 1'b1;
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || results.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  swa_divider #(
    .DIV_BITS (DIV_BITS),
    .LEN_BITS (LEN_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIV_BITS'(sum_mag) << FRACTION_BITS),
    .divisor  (eff_len),
    .negative (running_sum_next[SUM_BITS-1]),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.window_sum <= SUM_OUT_BITS'(running_sum);
      out_data.average_q8 <= AVG_OUT_BITS'(div_quotient);
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

`ifndef ASSERT_OFF
  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_UPDATE)
    else $error("sample accepted without entering update");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= eff_len)
    else $error("fill count beyond window length");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider finished outside divide state");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || results.ready))
    else $error("result register overwritten while held");
`endif

endmodule

@@ hdl/swa_divider.sv @@
// Restoring divider, one quotient bit per cycle, signed result from a magnitude.
module swa_divider
  import swa_pkg::*;
#(
  parameter int DIV_BITS = 30,
  parameter int LEN_BITS = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DIV_BITS-1:0]        dividend,
  input  logic [LEN_BITS-1:0]        divisor,
  input  logic                       negative,
  output logic                       done,
  output logic signed [DIV_BITS:0]   quotient
);

  localparam int CNT_BITS = $clog2(DIV_BITS + 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [DIV_BITS-1:0] acc;
  logic [LEN_BITS-1:0] rem;
  logic [LEN_BITS-1:0] dvs;
  logic                neg;

  logic [LEN_BITS:0]   rem_shift;
  logic                ge;
  logic [LEN_BITS-1:0] rem_next;
  logic [DIV_BITS-1:0] acc_next;
  logic signed [DIV_BITS:0] mag;

  always_comb begin
    rem_shift = {rem, acc[DIV_BITS-1]};
    ge        = rem_shift >= {1'b0, dvs};
    rem_next  = ge ? LEN_BITS'(rem_shift - {1'b0, dvs}) : LEN_BITS'(rem_shift);
    acc_next  = {acc[DIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIV_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
      neg <= negative;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign mag      = $signed({1'b0, acc});
  assign quotient = neg ? -mag : mag;

endmodule
